### src/snbc_pkg.sv
// ----------------------------------------------------------------------------
// snbc_pkg: shared types and constants for the signature norm bound check
// Widths, register indexes, status codes, stage structs and saturating add.
// ----------------------------------------------------------------------------
`default_nettype none

package snbc_pkg;

	// field and register widths
	localparam int COEF_W        = 51;
	localparam int MAG_W         = 50;
	localparam int SUM_W         = 64;
	localparam int L2_W          = 63;
	localparam int SHIFT_W       = 6;
	localparam int CFG_IDX_W     = 2;
	localparam int CFG_DATA_W    = 63;
	localparam int IN_TDATA_W    = 56;
	localparam int OUT_TDATA_W   = 8;

	// square operand width before saturation, and response magnitude pre-shift
	localparam int SQ_IN_W       = 32;
	localparam int RESP_SQ_SHIFT = 32;

	// register reset values
	localparam logic [MAG_W-1:0]   MODULUS_RST    = 50'd549824583172097;
	localparam logic [MAG_W-1:0]   MAX_BOUND_RST  = '0;
	localparam logic [L2_W-1:0]    L2_BOUND_RST   = '0;
	localparam logic [SHIFT_W-1:0] HINT_SHIFT_RST = 6'd44;

	// register indexes on the write port
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODULUS    = 2'd0,
		REG_MAX_BOUND  = 2'd1,
		REG_L2_BOUND   = 2'd2,
		REG_HINT_SHIFT = 2'd3
	} cfg_reg_t;

	// result codes
	typedef enum logic [1:0] {
		ST_PASS     = 2'd0,
		ST_HINT_MAX = 2'd1,
		ST_RESP_MAX = 2'd2,
		ST_L2_NORM  = 2'd3
	} status_t;

	typedef struct packed {
		logic [MAG_W-1:0]   modulus;
		logic [MAG_W-1:0]   max_bound;
		logic [L2_W-1:0]    l2_bound;
		logic [SHIFT_W-1:0] hint_shift;
	} cfg_t;

	// side data riding along the remainder pipeline
	typedef struct packed {
		logic             kind;
		logic             last;
		logic             neg;
		logic [MAG_W-1:0] sat_mag;
	} item_t;

	// final accumulator values of one signature
	typedef struct packed {
		logic [MAG_W-1:0] hint_max;
		logic [SUM_W-1:0] hint_sum;
		logic [MAG_W-1:0] resp_max;
		logic [SUM_W-1:0] resp_sum;
	} sums_t;

	// add that sticks at all ones on carry out
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
			input logic [SUM_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
	endfunction

endpackage

`default_nettype wire

### src/snbc_rem_pipe.sv
// ----------------------------------------------------------------------------
// snbc_rem_pipe: pipelined remainder of |coef| by the modulus
// One restoring compare/subtract step per stage, one bit of the dividend per
// stage; the sign and the saturated magnitude ride along for later stages.
// ----------------------------------------------------------------------------
`default_nettype none

module snbc_rem_pipe import snbc_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_valid,
	input  wire logic [COEF_W-1:0] in_coef,
	input  wire logic              in_kind,
	input  wire logic              in_last,
	input  wire logic [MAG_W-1:0]  modulus,
	output logic                   out_valid,
	output logic [MAG_W-1:0]       out_rem,
	output item_t                  out_item
);

	localparam int STEPS = COEF_W;

	logic              vld_s2  [0:STEPS];
	logic [COEF_W-1:0] dvd_s2  [0:STEPS];
	logic [MAG_W-1:0]  rem_s2  [0:STEPS];
	item_t             item_s2 [0:STEPS];
	logic [MAG_W-1:0]  rem_nxt [0:STEPS-1];

	logic              neg;
	logic [COEF_W-1:0] abs_val;
	item_t             item_in;

	// magnitude of the two's complement input
	assign neg     = in_coef[COEF_W-1];
	assign abs_val = neg ? (~in_coef + COEF_W'(1)) : in_coef;

	always_comb begin
		item_in.kind    = in_kind;
		item_in.last    = in_last;
		item_in.neg     = neg;
		item_in.sat_mag = abs_val[COEF_W-1] ? {MAG_W{1'b1}} : abs_val[MAG_W-1:0];
	end

	// one remainder step per stage, dividend MSB first
	for (genvar i = 0; i < STEPS; i++) begin : g_step
		logic [MAG_W:0] trial;
		assign trial      = {rem_s2[i], dvd_s2[i][COEF_W-1-i]};
		assign rem_nxt[i] = (trial >= {1'b0, modulus})
			? MAG_W'(trial - {1'b0, modulus}) : trial[MAG_W-1:0];
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= STEPS; k++) vld_s2[k] <= 1'b0;
		end else if (en) begin
			vld_s2[0] <= in_valid;
			for (int k = 0; k < STEPS; k++) vld_s2[k+1] <= vld_s2[k];
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s2[0]  <= abs_val;
			rem_s2[0]  <= '0;
			item_s2[0] <= item_in;
			for (int k = 0; k < STEPS; k++) begin
				dvd_s2[k+1]  <= dvd_s2[k];
				rem_s2[k+1]  <= rem_nxt[k];
				item_s2[k+1] <= item_s2[k];
			end
		end
	end

	assign out_valid = vld_s2[STEPS];
	assign out_rem   = rem_s2[STEPS];
	assign out_item  = item_s2[STEPS];

endmodule

`default_nettype wire

### src/snbc_accum.sv
// ----------------------------------------------------------------------------
// snbc_accum: magnitude, square and running accumulators
// Centers the remainder, squares the magnitude with saturation, keeps the
// maxima and saturating square sums, and hands the totals on at the last item.
// ----------------------------------------------------------------------------
`default_nettype none

module snbc_accum import snbc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             en,
	input  wire logic             in_valid,
	input  wire logic [MAG_W-1:0] in_rem,
	input  wire item_t            in_item,
	input  wire logic [MAG_W-1:0] modulus,
	output logic                  out_valid,
	output sums_t                 out_sums
);

	logic [MAG_W-1:0] half, diff, resp_mag, mag;

	logic             vld_s3, kind_s3, last_s3;
	logic [MAG_W-1:0] mag_s3;

	logic [MAG_W-1:0] sq_op;
	logic [SQ_IN_W-1:0] sq_lo;
	logic             sq_big;
	logic [SUM_W-1:0] prod;

	logic             vld_s4, kind_s4, last_s4;
	logic [MAG_W-1:0] mag_s4;
	logic [SUM_W-1:0] sq_s4;

	logic [MAG_W-1:0] hint_max_q, resp_max_q, hmax_nxt, rmax_nxt;
	logic [SUM_W-1:0] hint_sum_q, resp_sum_q, hsum_nxt, rsum_nxt;

	logic             vld_s5;
	sums_t            sums_s5;

	// center the remainder around zero and take its magnitude
	assign half = modulus >> 1;
	assign diff = modulus - in_rem;

	always_comb begin
		if (in_item.neg && (in_rem != '0)) begin
			resp_mag = (diff > half) ? in_rem : diff;
		end else begin
			resp_mag = (in_rem > half) ? diff : in_rem;
		end
		// hint items and a zero modulus use the plain saturated magnitude
		if (!in_item.kind || (modulus == '0)) begin
			mag = in_item.sat_mag;
		end else begin
			mag = resp_mag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s3  <= mag;
			kind_s3 <= in_item.kind;
			last_s3 <= in_item.last;
		end
	end

	// saturating square
	assign sq_op  = kind_s3 ? (mag_s3 >> RESP_SQ_SHIFT) : mag_s3;
	assign sq_big = |sq_op[MAG_W-1:SQ_IN_W];
	assign sq_lo  = sq_op[SQ_IN_W-1:0];
	assign prod   = SUM_W'(sq_lo) * SUM_W'(sq_lo);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s4   <= sq_big ? {SUM_W{1'b1}} : prod;
			mag_s4  <= mag_s3;
			kind_s4 <= kind_s3;
			last_s4 <= last_s3;
		end
	end

	// accumulator update
	always_comb begin
		hmax_nxt = (!kind_s4 && (mag_s4 > hint_max_q)) ? mag_s4 : hint_max_q;
		rmax_nxt = (kind_s4 && (mag_s4 > resp_max_q)) ? mag_s4 : resp_max_q;
		hsum_nxt = kind_s4 ? hint_sum_q : sat_add(hint_sum_q, sq_s4);
		rsum_nxt = kind_s4 ? sat_add(resp_sum_q, sq_s4) : resp_sum_q;
	end

	// accumulators clear after the last item of a signature
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hint_max_q <= '0;
			hint_sum_q <= '0;
			resp_max_q <= '0;
			resp_sum_q <= '0;
			vld_s5     <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4 && last_s4;
			if (vld_s4) begin
				if (last_s4) begin
					hint_max_q <= '0;
					hint_sum_q <= '0;
					resp_max_q <= '0;
					resp_sum_q <= '0;
				end else begin
					hint_max_q <= hmax_nxt;
					hint_sum_q <= hsum_nxt;
					resp_max_q <= rmax_nxt;
					resp_sum_q <= rsum_nxt;
				end
			end
		end
	end

	// totals including the last item
	always_ff @(posedge clk) begin
		if (en && vld_s4 && last_s4) begin
			sums_s5.hint_max <= hmax_nxt;
			sums_s5.hint_sum <= hsum_nxt;
			sums_s5.resp_max <= rmax_nxt;
			sums_s5.resp_sum <= rsum_nxt;
		end
	end

	assign out_valid = vld_s5;
	assign out_sums  = sums_s5;

endmodule

`default_nettype wire

### src/snbc_check.sv
// ----------------------------------------------------------------------------
// snbc_check: bound checks on the totals of one signature
// First stage: hint and response maxima against their bounds and scaling of
// the hint square sum; the combined sum compare follows from the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module snbc_check import snbc_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  en,
	input  wire logic  in_valid,
	input  wire sums_t in_sums,
	input  wire cfg_t  cfg,
	output logic       out_valid,
	output status_t    out_status
);

	localparam int SH_W = SHIFT_W + 1;
	localparam logic [SUM_W-1:0] ALL_ONES = {SUM_W{1'b1}};

	logic [SUM_W-1:0] round_sum, hint_bound, hs;
	logic [SH_W-1:0]  dbl, up_sh, dn_sh;
	logic             scale_up;

	logic             vld_s6, hint_fail_s6, resp_fail_s6;
	logic [SUM_W-1:0] hs_s6, rsum_s6, total;
	logic             l2_fail;

	// rounded hint bound: (max_bound + 2^(nu-1)) >> nu
	assign round_sum  = SUM_W'(cfg.max_bound)
		+ (SUM_W'(1) << (cfg.hint_shift - SHIFT_W'(1)));
	assign hint_bound = (cfg.hint_shift == '0) ? SUM_W'(cfg.max_bound)
		: (round_sum >> cfg.hint_shift);

	// hint sum scaled by 2^(2*nu-64), saturating on the way up
	assign dbl      = {cfg.hint_shift, 1'b0};
	assign up_sh    = dbl - SH_W'(SUM_W);
	assign dn_sh    = SH_W'(SUM_W) - dbl;
	assign scale_up = cfg.hint_shift >= SHIFT_W'(SUM_W / 2);

	always_comb begin
		if (scale_up) begin
			hs = (in_sums.hint_sum > (ALL_ONES >> up_sh)) ? ALL_ONES
				: (in_sums.hint_sum << up_sh);
		end else begin
			hs = in_sums.hint_sum >> dn_sh;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hint_fail_s6 <= SUM_W'(in_sums.hint_max) > hint_bound;
			resp_fail_s6 <= in_sums.resp_max > cfg.max_bound;
			hs_s6        <= hs;
			rsum_s6      <= in_sums.resp_sum;
		end
	end

	// combined norm and status priority
	assign total   = sat_add(hs_s6, rsum_s6);
	assign l2_fail = total > SUM_W'(cfg.l2_bound);

	always_comb begin
		if (hint_fail_s6) begin
			out_status = ST_HINT_MAX;
		end else if (resp_fail_s6) begin
			out_status = ST_RESP_MAX;
		end else if (l2_fail) begin
			out_status = ST_L2_NORM;
		end else begin
			out_status = ST_PASS;
		end
	end

	assign out_valid = vld_s6;

endmodule

`default_nettype wire

### src/signature_norm_bound_check.sv
// Path: a status passes the input register, the 51-step remainder pipeline,
// then the magnitude, square, accumulate, check and output registers.
// Throughput: one coefficient per cycle while the skid entry is free;
// one status per signature.
// Reset (arst_n low): registers return to their defaults, accumulators and
// all valid flags clear; no clearing pass, items are taken right after reset.
// ----------------------------------------------------------------------------
// signature_norm_bound_check: streaming norm check on signature coefficients
// Input register, remainder pipeline, accumulators, bound checks and a
// two-entry output buffer; configuration registers on a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module signature_norm_bound_check import snbc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	// configuration write port
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
	// coefficient stream
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,  // [50:0] coef, [55:51] zero
	input  wire logic                   s_tuser,  // [0] kind
	input  wire logic                   s_tlast,
	// status stream
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	output logic [OUT_TDATA_W-1:0]      m_tdata   // [1:0] status, [7:2] zero
);

	cfg_t              cfg_q;
	logic              en;

	logic              vld_s1, kind_s1, last_s1;
	logic [COEF_W-1:0] coef_s1;

	logic              rem_valid;
	logic [MAG_W-1:0]  rem_val;
	item_t             rem_item;

	logic              acc_valid;
	sums_t             acc_sums;

	logic              chk_valid, res_valid;
	status_t           chk_status;

	logic              out_valid_q, skid_valid_q;
	status_t           out_status_q, skid_status_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.modulus    <= MODULUS_RST;
			cfg_q.max_bound  <= MAX_BOUND_RST;
			cfg_q.l2_bound   <= L2_BOUND_RST;
			cfg_q.hint_shift <= HINT_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_MODULUS:    cfg_q.modulus    <= cfg_wdata[MAG_W-1:0];
				REG_MAX_BOUND:  cfg_q.max_bound  <= cfg_wdata[MAG_W-1:0];
				REG_L2_BOUND:   cfg_q.l2_bound   <= cfg_wdata[L2_W-1:0];
				REG_HINT_SHIFT: cfg_q.hint_shift <= cfg_wdata[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// whole pipeline moves while the skid entry is free
	assign en       = !skid_valid_q;
	assign s_tready = en;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			coef_s1 <= s_tdata[COEF_W-1:0];
			kind_s1 <= s_tuser;
			last_s1 <= s_tlast;
		end
	end

	snbc_rem_pipe u_rem (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (vld_s1),
		.in_coef   (coef_s1),
		.in_kind   (kind_s1),
		.in_last   (last_s1),
		.modulus   (cfg_q.modulus),
		.out_valid (rem_valid),
		.out_rem   (rem_val),
		.out_item  (rem_item)
	);

	snbc_accum u_acc (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (rem_valid),
		.in_rem    (rem_val),
		.in_item   (rem_item),
		.modulus   (cfg_q.modulus),
		.out_valid (acc_valid),
		.out_sums  (acc_sums)
	);

	snbc_check u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (acc_valid),
		.in_sums    (acc_sums),
		.cfg        (cfg_q),
		.out_valid  (chk_valid),
		.out_status (chk_status)
	);

	assign res_valid = en && chk_valid;

	// output register with one skid entry behind it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || m_tready) begin
			if (skid_valid_q) begin
				out_status_q <= skid_status_q;
			end else if (res_valid) begin
				out_status_q <= chk_status;
			end
		end else if (res_valid) begin
			skid_status_q <= chk_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'(out_status_q);

endmodule

`default_nettype wire

### src/snbc_checker.sv
// ----------------------------------------------------------------------------
// snbc_checker: port-level checks on the norm bound check block
// Watches the stream handshakes and the output buffering over time.
// ----------------------------------------------------------------------------
`default_nettype none

module snbc_checker import snbc_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tvalid,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata
);

	// a stalled status holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("status changed or dropped while stalled");

	// input only backs up while a status is waiting
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no status waiting");

	// input stall begins only after a refused status
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

	// with no status shown last cycle the input must be open
	a_ready_after_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(m_tvalid) |-> s_tready)
		else $error("input closed after an idle output");

endmodule

bind signature_norm_bound_check snbc_checker u_snbc_checker (.*);

`default_nettype wire

### bench/signature_norm_bound_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signature_norm_bound_check_tb: self-checking bench for the norm bound check
// Streams hint and response coefficients under several register settings,
// predicts each signature's status in a local model and scoreboards the
// status stream, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------

module signature_norm_bound_check_tb;
	import snbc_pkg::*;

	localparam logic KIND_HINT = 1'b0;
	localparam logic KIND_RESP = 1'b1;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [49:0] MAG_MAX = {MAG_W{1'b1}};
	localparam logic [50:0] COEF_MOST_NEG = {1'b1, {MAG_W{1'b0}}};
	localparam int DRAIN_CYCLES = 70;
	localparam int HOLD_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [COEF_W-1:0] coef;
		logic              kind;
		logic              last;
	} coef_item_t;

	logic clk;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;  // [50:0] coef, [55:51] zero
	logic s_tuser = 1'b0;                 // [0] kind
	logic s_tlast = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;      // [1:0] status, [7:2] zero

	signature_norm_bound_check dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// stimulus and scoreboard storage
	coef_item_t coef_q[$];
	status_t pending_status[$];
	int err_count = 0;

	// shadow registers
	logic [MAG_W-1:0]   q_mod     = MODULUS_RST;
	logic [MAG_W-1:0]   inf_bound = MAX_BOUND_RST;
	logic [L2_W-1:0]    l2_lim    = L2_BOUND_RST;
	logic [SHIFT_W-1:0] nu        = HINT_SHIFT_RST;

	// shadow accumulators
	logic [MAG_W-1:0] hint_peak   = '0;
	logic [SUM_W-1:0] hint_sq_acc = '0;
	logic [MAG_W-1:0] resp_peak   = '0;
	logic [SUM_W-1:0] resp_sq_acc = '0;

	// idling controls
	bit src_idle_on = 1'b1;
	bit sink_idle_on = 1'b1;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int hold_cnt = 0;
	int src_gap = 0;
	int sink_gap = 0;
	int quiet = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// status prediction
	// ------------------------------------------------------------------

	function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
		logic [63:0] s;
		s = a + b;
		return (s < a) ? ALL_ONES : s;
	endfunction

	function automatic logic [63:0] square_sat(logic [49:0] x);
		logic [63:0] w;
		w = {14'b0, x};
		if (x[49:32] != '0) return ALL_ONES;
		return w * w;
	endfunction

	// two's complement magnitude, clipped to the 50-bit width
	function automatic logic [49:0] mag_sat(logic [50:0] c);
		logic [50:0] m;
		m = c[50] ? (~c + 51'd1) : c;
		return m[50] ? MAG_MAX : m[49:0];
	endfunction

	// reduce into [0,q), then distance to zero around the ring
	function automatic logic [49:0] resp_mag(logic [50:0] coef);
		longint c;
		longint qs;
		longint t;
		logic [63:0] r;
		if (q_mod == '0) return mag_sat(coef);
		c = $signed({{13{coef[50]}}, coef});
		qs = $signed({14'b0, q_mod});
		t = c % qs;
		if (t < 0) t = t + qs;
		r = t;
		if (r > ({14'b0, q_mod} >> 1)) r = {14'b0, q_mod} - r;
		return r[49:0];
	endfunction

	function automatic logic [63:0] hint_limit();
		if (nu == '0) return {14'b0, inf_bound};
		return ({14'b0, inf_bound} + (64'd1 << (nu - 1))) >> nu;
	endfunction

	function automatic status_t signature_verdict();
		logic [63:0] scaled;
		logic [63:0] total;
		int sh;
		if ({14'b0, hint_peak} > hint_limit()) return ST_HINT_MAX;
		if (resp_peak > inf_bound) return ST_RESP_MAX;
		if (nu >= 32) begin
			sh = 2 * nu - 64;
			scaled = (hint_sq_acc > (ALL_ONES >> sh)) ? ALL_ONES : (hint_sq_acc << sh);
		end else begin
			sh = 64 - 2 * nu;
			scaled = (sh >= 64) ? 64'd0 : (hint_sq_acc >> sh);
		end
		total = add_sat(scaled, resp_sq_acc);
		return (total > {1'b0, l2_lim}) ? ST_L2_NORM : ST_PASS;
	endfunction

	function automatic void accumulate_coef(logic [50:0] coef, logic kind, logic last);
		logic [49:0] m;
		if (kind == KIND_HINT) begin
			m = mag_sat(coef);
			if (m > hint_peak) hint_peak = m;
			hint_sq_acc = add_sat(hint_sq_acc, square_sat(m));
		end else begin
			m = resp_mag(coef);
			if (m > resp_peak) resp_peak = m;
			resp_sq_acc = add_sat(resp_sq_acc, square_sat(m >> RESP_SQ_SHIFT));
		end
		if (last) begin
			pending_status.push_back(signature_verdict());
			hint_peak = '0;
			hint_sq_acc = '0;
			resp_peak = '0;
			resp_sq_acc = '0;
		end
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	function automatic logic [63:0] rand_below(logic [63:0] lim);
		logic [63:0] r;
		r = {$urandom, $urandom};
		if (lim == ALL_ONES) return r;
		return r % (lim + 64'd1);
	endfunction

	function automatic logic [50:0] signed_coef(logic [63:0] mag, bit neg);
		logic [50:0] v;
		v = (mag > {14'b0, MAG_MAX}) ? {1'b0, MAG_MAX} : {1'b0, mag[49:0]};
		return neg ? (~v + 51'd1) : v;
	endfunction

	// coefficient mostly near the bounds in force, sometimes anywhere
	function automatic logic [50:0] pick_coef(logic kind);
		logic [63:0] lim;
		longint v;
		bit neg;
		neg = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 9))
			0: return 51'({$urandom, $urandom});
			1: begin
				case ($urandom_range(0, 4))
					0: return '0;
					1: return 51'd1;
					2: return '1;
					3: return {1'b0, MAG_MAX};
					default: return COEF_MOST_NEG;
				endcase
			end
			default: begin
				if (kind == KIND_HINT) begin
					lim = hint_limit();
					return signed_coef(rand_below(lim + (lim >> 4) + 64'd1), neg);
				end
				lim = {14'b0, inf_bound};
				lim = rand_below(lim + (lim >> 4) + 64'd1);
				if (q_mod != '0 && $urandom_range(0, 1)) begin
					v = longint'($urandom_range(0, 8)) - 4;
					v = v * $signed({14'b0, q_mod});
					v = neg ? v - $signed(lim) : v + $signed(lim);
					if (v >= -(64'sd1 <<< 50) && v < (64'sd1 <<< 50)) return v[50:0];
				end
				return signed_coef(lim, neg);
			end
		endcase
	endfunction

	function automatic void push_coef(logic [50:0] coef, logic kind, logic last);
		coef_item_t it;
		it.coef = coef;
		it.kind = kind;
		it.last = last;
		coef_q.push_back(it);
	endfunction

	// whole signatures of random length, last flag on the final one
	function automatic void queue_signatures(int n);
		int added;
		int len;
		int bias;
		logic kind;
		added = 0;
		while (added < n) begin
			len = $urandom_range(1, 24);
			if (len > n - added) len = n - added;
			bias = $urandom_range(0, 3);
			for (int i = 0; i < len; i++) begin
				case (bias)
					0: kind = KIND_HINT;
					1: kind = KIND_RESP;
					default: kind = 1'($urandom_range(0, 1));
				endcase
				push_coef(pick_coef(kind), kind, i == len - 1);
			end
			added += len;
		end
	endfunction

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MODULUS:    q_mod = val[MAG_W-1:0];
			REG_MAX_BOUND:  inf_bound = val[MAG_W-1:0];
			REG_L2_BOUND:   l2_lim = val[L2_W-1:0];
			REG_HINT_SHIFT: nu = val[SHIFT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [49:0] q, logic [49:0] mb, logic [62:0] l2,
			logic [5:0] sh);
		write_reg(REG_MODULUS, {13'b0, q});
		write_reg(REG_MAX_BOUND, {13'b0, mb});
		write_reg(REG_L2_BOUND, l2);
		write_reg(REG_HINT_SHIFT, {57'b0, sh});
	endtask

	// wait until every queued item is taken and every status is back
	task automatic settle();
		while (coef_q.size() != 0 || s_tvalid || pending_status.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// coefficient driver
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap != 0) begin
				s_tvalid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (coef_q.size() == 0) begin
				s_tvalid <= 1'b0;
			end else if (src_idle_on && $urandom_range(0, 9) == 0) begin
				s_tvalid <= 1'b0;
				src_gap <= $urandom_range(0, 18);
			end else begin
				s_tvalid <= 1'b1;
				s_tdata <= {{(IN_TDATA_W - COEF_W){1'b0}}, coef_q[0].coef};
				s_tuser <= coef_q[0].kind;
				s_tlast <= coef_q[0].last;
				void'(coef_q.pop_front());
			end
		end
	end

	// ------------------------------------------------------------------
	// status receiver: random stalls plus one long hold-off
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_req && !hold_done) begin
			m_tready <= 1'b0;
			hold_cnt <= hold_cnt + 1;
			if (hold_cnt == HOLD_CYCLES - 1) hold_done <= 1'b1;
		end else if (sink_gap != 0) begin
			m_tready <= 1'b0;
			sink_gap <= sink_gap - 1;
		end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
			m_tready <= 1'b0;
			sink_gap <= $urandom_range(0, 18);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------
	// monitor and scoreboard
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				accumulate_coef(s_tdata[COEF_W-1:0], s_tuser, s_tlast);
			if (m_tvalid && m_tready) begin
				if (pending_status.size() == 0) begin
					$error("status: expected none, got %0d", m_tdata[1:0]);
					err_count++;
				end else begin
					if (m_tdata[1:0] != pending_status[0]) begin
						$error("status: expected %0d, got %0d",
							pending_status[0], m_tdata[1:0]);
						err_count++;
					end
					void'(pending_status.pop_front());
				end
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet <= 0;
		end else begin
			quiet <= quiet + 1;
			if (quiet == WATCHDOG_LIMIT) begin
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------
	initial begin
		logic [49:0] q;
		logic [5:0] sh;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: zero bounds, so any nonzero magnitude fails
		push_coef('0, KIND_HINT, 1'b1);
		push_coef(51'd1, KIND_HINT, 1'b1);
		push_coef(51'd1, KIND_RESP, 1'b1);
		push_coef({1'b0, MAG_MAX}, KIND_RESP, 1'b1);
		push_coef(COEF_MOST_NEG, KIND_HINT, 1'b0);
		push_coef('1, KIND_RESP, 1'b1);
		settle();

		// zero modulus and zero hint shift, widest bounds; squares and sums saturate
		configure('0, MAG_MAX, {L2_W{1'b1}}, 6'd0);
		push_coef(COEF_MOST_NEG, KIND_RESP, 1'b0);
		push_coef({1'b0, MAG_MAX}, KIND_HINT, 1'b0);
		push_coef(COEF_MOST_NEG, KIND_HINT, 1'b0);
		push_coef(51'd12345, KIND_RESP, 1'b1);
		settle();

		// modulus one, hint shift below 32
		configure(50'd1, '0, '0, 6'd31);
		push_coef(-51'sd5, KIND_RESP, 1'b0);
		push_coef('0, KIND_HINT, 1'b1);
		push_coef({1'b0, MAG_MAX}, KIND_RESP, 1'b1);
		settle();

		// modulus two, smallest regular shift
		configure(50'd2, 50'd1, '0, 6'd32);
		push_coef(-51'sd3, KIND_RESP, 1'b1);
		push_coef(51'd1, KIND_HINT, 1'b1);
		settle();

		// largest modulus and shift; centred values just past q/2
		configure(MAG_MAX, MAG_MAX, 63'd5, 6'd63);
		push_coef(51'd1 << 49, KIND_RESP, 1'b0);
		push_coef(-(51'sd1 <<< 49), KIND_RESP, 1'b1);
		settle();

		// typical settings: small hints, responses around multiples of q
		configure(MODULUS_RST, 50'd1 << 45, 63'd1 << 40, 6'd40);
		push_coef(-51'sd32, KIND_HINT, 1'b0);
		push_coef(51'd1 << 45, KIND_RESP, 1'b0);
		push_coef({1'b0, MODULUS_RST} * 51'd3 + 51'd7, KIND_RESP, 1'b1);
		settle();

		// random settings, one per phase
		for (int p = 0; p < 7; p++) begin
			case ($urandom_range(0, 5))
				0: q = 50'($urandom_range(0, 2));
				1: q = MAG_MAX;
				2: q = MODULUS_RST;
				default: q = 50'(rand_below({14'b0, MAG_MAX}));
			endcase
			sh = 6'(($urandom_range(0, 9) < 7) ? $urandom_range(32, 63)
				: $urandom_range(0, 31));
			configure(q, 50'(rand_below((64'd1 << $urandom_range(0, 50)) - 64'd1)),
				63'(rand_below((64'd1 << $urandom_range(0, 63)) - 64'd1)), sh);
			src_idle_on = $urandom_range(0, 3) != 0;
			sink_idle_on = $urandom_range(0, 3) != 0;
			queue_signatures(90);
			settle();
		end

		// long output hold-off while one-coefficient signatures keep coming
		configure(MODULUS_RST, 50'd1 << 44, 63'd1 << 30, 6'd44);
		src_idle_on = 1'b0;
		sink_idle_on = 1'b1;
		hold_req = 1'b1;
		for (int i = 0; i < 100; i++)
			push_coef(pick_coef(i[0]), i[0], 1'b1);
		settle();

		// closing stretch without idling
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		queue_signatures(60);
		settle();

		if (err_count == 0 && pending_status.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
